// ===== src/rlsp_pkg.sv =====
package rlsp_pkg;

  // Parser position within the byte stream.
  typedef enum logic [1:0] {
    PH_REG     = 2'd0,
    PH_DATA    = 2'd1,
    PH_WAIT_HI = 2'd2,
    PH_WAIT_LO = 2'd3
  } phase_t;

  // Command kinds handed from the parser to the output sequencer.
  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_WAIT    = 2'd1,
    CMD_SILENCE = 2'd2
  } cmd_kind_t;

  // Result actions on the output stream.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_WAIT  = 1'b1;

  // Input item kinds.
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_START = 1'b1;

  // Chip types selected by the configuration register.
  localparam logic [1:0] CHIP_TYPE0 = 2'd0;
  localparam logic [1:0] CHIP_TYPE1 = 2'd1;
  localparam logic [1:0] CHIP_TYPE2 = 2'd2;
  localparam logic [1:0] CHIP_TYPE3 = 2'd3;

  // Special register numbers in the stream.
  localparam logic [7:0] REG_FRAME_END = 8'd254;
  localparam logic [7:0] REG_TRACK_END = 8'd255;

  // Slack added to a late wait target.
  localparam logic [15:0] WAIT_SLACK = 16'd8;

  // Silence sequences are at most five writes long.
  localparam int unsigned SIL_IDX_W = 3;

  // One queued command.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  addr;
    logic [7:0]  data;
    logic [15:0] target;
    logic        over;
  } cmd_t;

  // Number of writes in the silence sequence of a chip type.
  function automatic logic [SIL_IDX_W-1:0] silence_len(input logic [1:0] chip);
    logic [SIL_IDX_W-1:0] n;
    unique case (chip)
      CHIP_TYPE0: n = 3'd5;
      CHIP_TYPE1: n = 3'd4;
      CHIP_TYPE2: n = 3'd4;
      CHIP_TYPE3: n = 3'd1;
      default:    n = 3'd1;
    endcase
    return n;
  endfunction

  // Register address of one silence write.
  function automatic logic [7:0] silence_addr(input logic [1:0] chip,
                                              input logic [SIL_IDX_W-1:0] idx);
    logic [7:0] a;
    a = 8'd0;
    unique case (chip)
      CHIP_TYPE0: begin
        unique case (idx)
          3'd0:    a = 8'd24;
          3'd1:    a = 8'd23;
          3'd2:    a = 8'd4;
          3'd3:    a = 8'd11;
          default: a = 8'd18;
        endcase
      end
      CHIP_TYPE1: a = 8'd0;
      CHIP_TYPE2: a = 8'd7 + {5'd0, idx};
      default:    a = 8'd15;
    endcase
    return a;
  endfunction

  // Data byte of one silence write.
  function automatic logic [7:0] silence_data(input logic [1:0] chip,
                                              input logic [SIL_IDX_W-1:0] idx);
    logic [7:0] d;
    d = 8'd0;
    unique case (chip)
      CHIP_TYPE0: d = (idx == 3'd0) ? 8'd128 : 8'd0;
      CHIP_TYPE1: begin
        unique case (idx)
          3'd0:    d = 8'b1001_1111;
          3'd1:    d = 8'b1011_1111;
          3'd2:    d = 8'b1101_1111;
          default: d = 8'b1111_1111;
        endcase
      end
      default:    d = 8'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== src/rlsp_front.sv =====
module rlsp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                kind,
  input  logic [7:0]          stream_byte,
  input  logic [15:0]         timer_count,
  output logic                push,
  output rlsp_pkg::cmd_t      cmd
);

  rlsp_pkg::phase_t phase_r, phase_nxt;
  logic             playing_r, playing_nxt;
  logic [7:0]       held_reg_r, held_reg_nxt;
  logic [7:0]       wait_hi_r, wait_hi_nxt;
  logic [15:0]      wait_cnt;

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= rlsp_pkg::PH_REG;
      playing_r  <= 1'b0;
      held_reg_r <= 8'd0;
      wait_hi_r  <= 8'd0;
    end else begin
      phase_r    <= phase_nxt;
      playing_r  <= playing_nxt;
      held_reg_r <= held_reg_nxt;
      wait_hi_r  <= wait_hi_nxt;
    end
  end

  assign wait_cnt = {wait_hi_r, stream_byte};

  // Classify each accepted transaction and build its command.
  always_comb begin
    phase_nxt    = phase_r;
    playing_nxt  = playing_r;
    held_reg_nxt = held_reg_r;
    wait_hi_nxt  = wait_hi_r;
    push         = 1'b0;
    cmd.kind     = rlsp_pkg::CMD_WRITE;
    cmd.addr     = held_reg_r;
    cmd.data     = stream_byte;
    cmd.target   = wait_cnt;
    cmd.over     = 1'b0;
    if (accept) begin
      if (kind == rlsp_pkg::KIND_START) begin
        phase_nxt   = rlsp_pkg::PH_REG;
        playing_nxt = 1'b1;
        push        = 1'b1;
        cmd.kind    = rlsp_pkg::CMD_SILENCE;
      end else if (playing_r) begin
        unique case (phase_r)
          rlsp_pkg::PH_REG: begin
            held_reg_nxt = stream_byte;
            phase_nxt    = rlsp_pkg::PH_DATA;
          end
          rlsp_pkg::PH_DATA: begin
            if (held_reg_r == rlsp_pkg::REG_TRACK_END) begin
              phase_nxt   = rlsp_pkg::PH_REG;
              playing_nxt = 1'b0;
              push        = 1'b1;
              cmd.kind    = rlsp_pkg::CMD_SILENCE;
              cmd.over    = 1'b1;
            end else if (held_reg_r == rlsp_pkg::REG_FRAME_END) begin
              phase_nxt = rlsp_pkg::PH_WAIT_HI;
            end else begin
              phase_nxt = rlsp_pkg::PH_REG;
              push      = 1'b1;
            end
          end
          rlsp_pkg::PH_WAIT_HI: begin
            wait_hi_nxt = stream_byte;
            phase_nxt   = rlsp_pkg::PH_WAIT_LO;
          end
          default: begin
            // Wait command; a late frame aims a little past the current timer value.
            phase_nxt = rlsp_pkg::PH_REG;
            push      = 1'b1;
            cmd.kind  = rlsp_pkg::CMD_WAIT;
            if (timer_count > wait_cnt) begin
              cmd.target = timer_count + rlsp_pkg::WAIT_SLACK;
            end
          end
        endcase
      end
    end
  end

endmodule

// ===== src/rlsp_queue.sv =====
module rlsp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rlsp_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output rlsp_pkg::cmd_t head_cmd
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  rlsp_pkg::cmd_t   slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Command storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== src/rlsp_back.sv =====
module rlsp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     chip_select,
  input  logic           head_valid,
  input  rlsp_pkg::cmd_t head_cmd,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           action,
  output logic [7:0]     reg_addr,
  output logic [7:0]     reg_data,
  output logic [15:0]    wait_target,
  output logic           track_over,
  output logic           last
);

  localparam int unsigned IW = rlsp_pkg::SIL_IDX_W;

  logic          valid_r, valid_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          load;
  logic          act_nxt, over_nxt, last_nxt;
  logic [7:0]    addr_nxt, data_nxt;
  logic [15:0]   target_nxt;
  logic          act_r, over_r, last_r;
  logic [7:0]    addr_r, data_r;
  logic [15:0]   target_r;

  // The output register takes a new result when empty or being drained.
  assign load = !valid_r || out_ready;

  // Expand the head command into results, one per cycle while the output register can load.
  always_comb begin
    valid_nxt  = valid_r;
    idx_nxt    = idx_r;
    pop        = 1'b0;
    act_nxt    = rlsp_pkg::ACT_WRITE;
    addr_nxt   = head_cmd.addr;
    data_nxt   = head_cmd.data;
    target_nxt = 16'd0;
    over_nxt   = 1'b0;
    last_nxt   = 1'b1;
    if (load) begin
      valid_nxt = head_valid;
      if (head_valid) begin
        unique case (head_cmd.kind)
          rlsp_pkg::CMD_WRITE: begin
            pop = 1'b1;
          end
          rlsp_pkg::CMD_WAIT: begin
            pop        = 1'b1;
            act_nxt    = rlsp_pkg::ACT_WAIT;
            addr_nxt   = 8'd0;
            data_nxt   = 8'd0;
            target_nxt = head_cmd.target;
          end
          default: begin
            // Silence burst: step through the chip's table.
            addr_nxt = rlsp_pkg::silence_addr(chip_select, idx_r);
            data_nxt = rlsp_pkg::silence_data(chip_select, idx_r);
            over_nxt = head_cmd.over;
            last_nxt = (idx_r == rlsp_pkg::silence_len(chip_select) - 1'b1);
            if (last_nxt) begin
              pop     = 1'b1;
              idx_nxt = '0;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      act_r    <= act_nxt;
      addr_r   <= addr_nxt;
      data_r   <= data_nxt;
      target_r <= target_nxt;
      over_r   <= over_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_valid   = valid_r;
  assign action      = act_r;
  assign reg_addr    = addr_r;
  assign reg_data    = data_r;
  assign wait_target = target_r;
  assign track_over  = over_r;
  assign last        = last_r;

endmodule

// ===== src/register_log_stream_player.sv =====
// A command is registered in the command queue, and its results in the output register.
// Throughput: one input transaction per cycle while the queue is not full; one result per
// cycle while out_tready is high. A start or end-of-track transaction expands into one to
// five results, paced by the output sequencer; the command queue absorbs bursts until full.
// Reset (rst_n low, synchronous) clears the parser, queue and output register,
// leaves playback disarmed and sets the chip type to zero.
module register_log_stream_player #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,   // chip_select
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // [7:0] stream_byte, [23:8] timer_count
  input  logic        in_tuser,      // [0] kind
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // [7:0] reg_addr, [15:8] reg_data, [31:16] wait_target
  output logic [1:0]  out_tuser,     // [0] action, [1] track_over
  output logic        out_tlast
);

  logic [1:0]     chip_sel_r;
  logic           in_accept;
  logic           push, pop, q_full, head_valid;
  rlsp_pkg::cmd_t push_cmd, head_cmd;
  logic           action, track_over;
  logic [7:0]     reg_addr, reg_data;
  logic [15:0]    wait_target;

  // Chip type register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip_sel_r <= rlsp_pkg::CHIP_TYPE0;
    end else if (cfg_wr_en) begin
      chip_sel_r <= cfg_wr_data;
    end
  end

  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  rlsp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .kind        (in_tuser),
    .stream_byte (in_tdata[7:0]),
    .timer_count (in_tdata[23:8]),
    .push        (push),
    .cmd         (push_cmd)
  );

  rlsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  rlsp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .chip_select (chip_sel_r),
    .head_valid  (head_valid),
    .head_cmd    (head_cmd),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .action      (action),
    .reg_addr    (reg_addr),
    .reg_data    (reg_data),
    .wait_target (wait_target),
    .track_over  (track_over),
    .last        (out_tlast)
  );

  // Pack the result fields onto the stream.
  assign out_tdata = {wait_target, reg_data, reg_addr};
  assign out_tuser = {track_over, action};

endmodule

// ===== verif/rlsp_result_checker.sv =====
`timescale 1ns / 1ps

// Watches the configuration, input and result channels of the stream player.
// It predicts the results of every accepted input transaction and compares each
// accepted result transaction with the oldest prediction.
module rlsp_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,   // chip_select
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,      // [7:0] stream_byte, [23:8] timer_count
  input  logic        in_tuser,      // [0] kind
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,     // [7:0] reg_addr, [15:8] reg_data, [31:16] wait_target
  input  logic [1:0]  out_tuser,     // [0] action, [1] track_over
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending
);

  // One predicted chip write or frame wait.
  typedef struct packed {
    logic        action;
    logic [7:0]  addr;
    logic [7:0]  data;
    logic [15:0] target;
    logic        over;
    logic        last;
  } chip_action_t;

  // Shadow copy of the player state and its configuration.
  rlsp_pkg::phase_t parse_at;
  logic [7:0]       held_reg;
  logic [7:0]       wait_hi;
  logic             armed;
  logic [1:0]       chip_sel;

  chip_action_t chip_action_q[$];
  int           errs;

  initial begin
    fail_count = 0;
    pending    = 0;
    errs       = 0;
  end

  // Appends the silence writes of the selected chip type.
  task automatic queue_silence(input logic over);
    logic [7:0] addrs [5];
    logic [7:0] datas [5];
    int         n;
    case (chip_sel)
      rlsp_pkg::CHIP_TYPE0: begin
        n     = 5;
        addrs = '{8'd24, 8'd23, 8'd4, 8'd11, 8'd18};
        datas = '{8'd128, 8'd0, 8'd0, 8'd0, 8'd0};
      end
      rlsp_pkg::CHIP_TYPE1: begin
        n     = 4;
        addrs = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        datas = '{8'h9F, 8'hBF, 8'hDF, 8'hFF, 8'h00};
      end
      rlsp_pkg::CHIP_TYPE2: begin
        n     = 4;
        addrs = '{8'd7, 8'd8, 8'd9, 8'd10, 8'd0};
        datas = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
      end
      default: begin
        n     = 1;
        addrs = '{8'd15, 8'd0, 8'd0, 8'd0, 8'd0};
        datas = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
      end
    endcase
    for (int i = 0; i < n; i++) begin
      chip_action_q.push_back('{action: rlsp_pkg::ACT_WRITE, addr: addrs[i], data: datas[i],
                                target: 16'd0, over: over, last: (i == n - 1)});
    end
  endtask

  // Advances the parser by one input transaction and queues what it emits.
  task automatic advance_player(input logic kind, input logic [7:0] b,
                                input logic [15:0] t);
    logic [15:0] count;
    logic [15:0] goal;
    if (kind == rlsp_pkg::KIND_START) begin
      parse_at = rlsp_pkg::PH_REG;
      armed    = 1'b1;
      queue_silence(1'b0);
    end else if (armed) begin
      case (parse_at)
        rlsp_pkg::PH_REG: begin
          held_reg = b;
          parse_at = rlsp_pkg::PH_DATA;
        end
        rlsp_pkg::PH_DATA: begin
          if (held_reg == rlsp_pkg::REG_TRACK_END) begin
            parse_at = rlsp_pkg::PH_REG;
            armed    = 1'b0;
            queue_silence(1'b1);
          end else if (held_reg == rlsp_pkg::REG_FRAME_END) begin
            parse_at = rlsp_pkg::PH_WAIT_HI;
          end else begin
            parse_at = rlsp_pkg::PH_REG;
            chip_action_q.push_back('{action: rlsp_pkg::ACT_WRITE, addr: held_reg, data: b,
                                      target: 16'd0, over: 1'b0, last: 1'b1});
          end
        end
        rlsp_pkg::PH_WAIT_HI: begin
          wait_hi  = b;
          parse_at = rlsp_pkg::PH_WAIT_LO;
        end
        default: begin
          // A timer that already ran past the count gets a short slack instead.
          count    = {wait_hi, b};
          goal     = (t > count) ? t + rlsp_pkg::WAIT_SLACK : count;
          parse_at = rlsp_pkg::PH_REG;
          chip_action_q.push_back('{action: rlsp_pkg::ACT_WAIT, addr: 8'd0, data: 8'd0,
                                    target: goal, over: 1'b0, last: 1'b1});
        end
      endcase
    end
  endtask

  task automatic flag_field(input string field, input logic [15:0] want,
                            input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      errs++;
    end
  endtask

  // Sample all channels at the clock edge, before the edge's own updates land.
  always @(posedge clk) begin : watch
    chip_action_t want;
    if (!rst_n) begin
      parse_at = rlsp_pkg::PH_REG;
      held_reg = 8'd0;
      wait_hi  = 8'd0;
      armed    = 1'b0;
      chip_sel = rlsp_pkg::CHIP_TYPE0;
      chip_action_q.delete();
    end else begin
      if (cfg_wr_en) begin
        chip_sel = cfg_wr_data;
      end
      if (in_tvalid && in_tready) begin
        advance_player(in_tuser, in_tdata[7:0], in_tdata[23:8]);
      end
      if (out_tvalid && out_tready) begin
        if (chip_action_q.size() == 0) begin
          $display("%0t: unexpected result, actual tdata 0x%0h tuser 0x%0h tlast %0b",
                   $time, out_tdata, out_tuser, out_tlast);
          errs++;
        end else begin
          want = chip_action_q.pop_front();
          flag_field("action", {15'd0, want.action}, {15'd0, out_tuser[0]});
          flag_field("reg_addr", {8'd0, want.addr}, {8'd0, out_tdata[7:0]});
          flag_field("reg_data", {8'd0, want.data}, {8'd0, out_tdata[15:8]});
          flag_field("wait_target", want.target, out_tdata[31:16]);
          flag_field("track_over", {15'd0, want.over}, {15'd0, out_tuser[1]});
          flag_field("last", {15'd0, want.last}, {15'd0, out_tlast});
        end
      end
    end
    fail_count <= errs;
    pending    <= chip_action_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS   = 48;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [1:0]  cfg_wr_data = 2'd0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata    = 24'd0;
  logic        in_tuser    = rlsp_pkg::KIND_BYTE;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  int          mismatches;
  int          outstanding;
  bit          src_quiet   = 1'b0;
  bit          sink_quiet  = 1'b0;
  int unsigned sink_hold   = 0;
  int unsigned cycles      = 0;

  always #2 clk = ~clk;

  register_log_stream_player dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  rlsp_result_checker results_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (mismatches),
    .pending    (outstanding)
  );

  // Result side: after each result transaction, deassert out_tready for a drawn gap.
  always @(posedge clk) begin : sink_side
    int unsigned nxt;
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_hold  <= 0;
    end else if (out_tvalid && out_tready) begin
      nxt = sink_quiet ? 0 : $urandom_range(0, 14);
      out_tready <= (nxt == 0);
      sink_hold  <= nxt;
    end else if (sink_hold != 0) begin
      out_tready <= (sink_hold == 1);
      sink_hold  <= sink_hold - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offers one transaction after a drawn gap and holds it until accepted.
  task automatic push_item(input logic kind, input logic [7:0] b, input logic [15:0] t);
    int unsigned gap;
    gap = src_quiet ? 0 : $urandom_range(0, 14);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {t, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_item(rlsp_pkg::KIND_BYTE, b, 16'($urandom));
  endtask

  task automatic push_start();
    push_item(rlsp_pkg::KIND_START, 8'($urandom), 16'($urandom));
  endtask

  task automatic push_pair(input logic [7:0] r, input logic [7:0] d);
    push_byte(r);
    push_byte(d);
  endtask

  // Frame end: marker pair, then the big-endian count; the timer rides on the low byte.
  task automatic push_frame_end(input logic [15:0] count, input logic [15:0] t);
    push_pair(rlsp_pkg::REG_FRAME_END, 8'($urandom));
    push_byte(count[15:8]);
    push_item(rlsp_pkg::KIND_BYTE, count[7:0], t);
  endtask

  // Timer values clustered around the count, plus the extremes.
  function automatic logic [15:0] pick_timer(input logic [15:0] count);
    logic [15:0] t;
    case ($urandom_range(0, 5))
      0:       t = count;
      1:       t = count + 16'($urandom_range(1, 16));
      2:       t = count - 16'($urandom_range(1, 16));
      3:       t = 16'hFFFF;
      4:       t = 16'h0000;
      default: t = 16'($urandom);
    endcase
    return t;
  endfunction

  // Stops sending until every predicted result has arrived and the pipe is empty.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_chip(input logic [1:0] sel);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= sel;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly well-formed streams with random content, some restarts and noise.
  task automatic run_stream(input int unsigned n_items);
    int unsigned done;
    int unsigned sel;
    int unsigned extra;
    logic [15:0] count;
    push_start();
    done = 1;
    while (done < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 62) begin
        push_pair(8'($urandom_range(0, 253)), 8'($urandom));
        done += 2;
      end else if (sel < 80) begin
        count = 16'($urandom);
        push_frame_end(count, pick_timer(count));
        done += 4;
      end else if (sel < 86) begin
        // End of track, a few bytes that must be ignored, then a fresh start.
        extra = $urandom_range(0, 3);
        push_pair(rlsp_pkg::REG_TRACK_END, 8'($urandom));
        repeat (extra) push_byte(8'($urandom));
        push_start();
        done += 3 + extra;
      end else if (sel < 92) begin
        push_start();
        done += 1;
      end else begin
        push_byte(8'($urandom));
        done += 1;
      end
    end
  endtask

  initial begin : stimulus
    logic [1:0] chip_order [4];
    chip_order = '{rlsp_pkg::CHIP_TYPE3, rlsp_pkg::CHIP_TYPE1, rlsp_pkg::CHIP_TYPE2,
                   rlsp_pkg::CHIP_TYPE0};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on the reset chip type.
    push_item(rlsp_pkg::KIND_BYTE, 8'hFF, 16'hFFFF);
    push_item(rlsp_pkg::KIND_BYTE, 8'h00, 16'h0000);
    push_item(rlsp_pkg::KIND_START, 8'hFF, 16'hFFFF);
    push_pair(8'h00, 8'h00);
    push_pair(8'd253, 8'hFF);
    push_frame_end(16'h0000, 16'h0000);
    push_frame_end(16'hFFFF, 16'hFFFF);
    push_frame_end(16'h0010, 16'hFFFA);
    push_frame_end(16'h8000, 16'h7FFF);
    push_byte(8'h07);
    push_item(rlsp_pkg::KIND_START, 8'h00, 16'h0000);
    push_pair(rlsp_pkg::REG_TRACK_END, 8'hAB);
    push_byte(8'h12);
    push_start();
    push_pair(8'h80, 8'h55);

    // Random phases, each with its own chip type and idling mix.
    for (int ph = 0; ph < 8; ph++) begin
      set_chip(ph < 4 ? chip_order[ph] : 2'($urandom));
      src_quiet  = (ph == 0 || ph == 2) ? 1'b1 : ($urandom_range(0, 3) == 0);
      sink_quiet = (ph == 1 || ph == 2) ? 1'b1 : ($urandom_range(0, 3) == 0);
      run_stream(PHASE_ITEMS);
    end

    drain_results();
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
